FILE: rtl/pfcp_pkg.sv
// ----------------------------------------------------------------------------
// pfcp_pkg: shared types and constants of the pipe field command parser
// Keyword tables, number limits, result kinds and the queue entry type.
// ----------------------------------------------------------------------------
package pfcp_pkg;

  localparam int QUERY_CAP_DEF   = 32;
  localparam int PAYLOAD_CAP_DEF = 256;
  localparam int QUEUE_DEPTH     = 4;

  localparam int ID_W  = 27;
  localparam int LVL_W = 8;
  localparam int KND_W = 3;
  localparam int NKW   = 7;

  localparam logic [ID_W-1:0] ID_MAX     = 27'h7FFFFFF;
  localparam logic [ID_W-1:0] LEVEL_MAX  = 27'd255;
  localparam logic [7:0]      SEP        = 8'h7C;
  localparam logic [3:0]      MAX_DIGITS = 4'd9;

  // Keyword indexes into the candidate vector.
  localparam int KW_FUNC   = 0;
  localparam int KW_GM     = 1;
  localparam int KW_API    = 2;
  localparam int KW_BUTTON = 3;
  localparam int KW_SLIDER = 4;
  localparam int KW_RUN    = 5;
  localparam int KW_STOP   = 6;
  localparam logic [NKW-1:0] KW_ALL = '1;

  // Result kinds.
  localparam logic [KND_W-1:0] KIND_UNKNOWN  = 3'd0;
  localparam logic [KND_W-1:0] KIND_BUTTON   = 3'd1;
  localparam logic [KND_W-1:0] KIND_SLIDER   = 3'd2;
  localparam logic [KND_W-1:0] KIND_FUNCTION = 3'd3;
  localparam logic [KND_W-1:0] KIND_GM       = 3'd4;
  localparam logic [KND_W-1:0] KIND_API      = 3'd5;

  // One classified byte: an optional text result and an optional verdict.
  typedef struct packed {
    logic              has_text;
    logic [7:0]        text_byte;
    logic              text_part;
    logic              has_verdict;
    logic              malformed;
    logic [KND_W-1:0]  kind;
    logic [ID_W-1:0]   ident;
    logic [LVL_W-1:0]  level;
    logic              running;
  } pfcp_entry_t;

  function automatic logic [7:0] kw_char(input int k, input logic [2:0] pos);
    logic [63:0] row;
    case (k)
      KW_FUNC:   row = "FUNCTION";
      KW_GM:     row = {"GM_", "VALUE"};
      KW_API:    row = {"QLC", "+API", 8'h00};
      KW_BUTTON: row = {"BUTTON", 16'h0000};
      KW_SLIDER: row = {"SLIDER", 16'h0000};
      KW_RUN:    row = {"Running", 8'h00};
      KW_STOP:   row = {"Stopped", 8'h00};
      default:   row = '0;
    endcase
    // The first character sits in the top byte of the string literal.
    return row[(7 - int'(pos)) * 8 +: 8];
  endfunction

  function automatic logic [3:0] kw_len(input int k);
    case (k)
      KW_FUNC, KW_GM:                  return 4'd8;
      KW_API, KW_RUN, KW_STOP:         return 4'd7;
      default:                         return 4'd6;
    endcase
  endfunction

  function automatic logic kw_hit(input logic [NKW-1:0] cand, input logic [3:0] pos,
                                  input int k);
    return cand[k] && (pos == kw_len(k));
  endfunction

  function automatic logic num_ok(input logic bad, input logic [3:0] cnt,
                                  input logic [ID_W-1:0] acc,
                                  input logic [ID_W-1:0] max);
    return !bad && (cnt != 4'd0) && (acc <= max);
  endfunction

endpackage

FILE: rtl/pfcp_queue.sv
// ----------------------------------------------------------------------------
// pfcp_queue: short register queue between the parser front and back
// First-in first-out store of classified entries with a full and empty flag.
// ----------------------------------------------------------------------------
module pfcp_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/pfcp_front.sv
// ----------------------------------------------------------------------------
// pfcp_front: byte parser front end built on a field state machine
// Takes one byte a cycle unless the queue is full; queues text and verdicts.
// ----------------------------------------------------------------------------
module pfcp_front #(
  parameter int QUERY_CAP   = 32,
  parameter int PAYLOAD_CAP = 256
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,
  input  logic                s_axis_tlast,
  output logic                q_push,
  output pfcp_pkg::pfcp_entry_t q_entry,
  input  logic                q_full
);
  import pfcp_pkg::*;

  localparam int CAP_MAX = (PAYLOAD_CAP > QUERY_CAP) ? PAYLOAD_CAP : QUERY_CAP;
  localparam int CNT_W   = $clog2(CAP_MAX);

  localparam logic [3:0] PH_HEAD    = 4'd0;
  localparam logic [3:0] PH_FID     = 4'd1;
  localparam logic [3:0] PH_FSTATE  = 4'd2;
  localparam logic [3:0] PH_GMV     = 4'd3;
  localparam logic [3:0] PH_QUERY   = 4'd4;
  localparam logic [3:0] PH_PAYLOAD = 4'd5;
  localparam logic [3:0] PH_WTYPE   = 4'd6;
  localparam logic [3:0] PH_WVAL    = 4'd7;
  localparam logic [3:0] PH_DONE    = 4'd8;

  logic [3:0]       phase,   phase_next;
  logic [NKW-1:0]   cand,    cand_next;
  logic [3:0]       pos,     pos_next;
  logic [ID_W-1:0]  acc,     acc_next;
  logic [3:0]       dcnt,    dcnt_next;
  logic             nbad,    nbad_next;
  logic [ID_W-1:0]  hident,  hident_next;
  logic [LVL_W-1:0] hlevel,  hlevel_next;
  logic [KND_W-1:0] hkind,   hkind_next;
  logic             hrun,    hrun_next;
  logic [CNT_W-1:0] tcnt,    tcnt_next;
  logic             ferr,    ferr_next;

  logic [7:0]       b;
  logic             accept;
  logic             is_sep;
  logic             is_digit;
  logic [3:0]       dval;
  logic [ID_W+3:0]  prod;
  logic [NKW-1:0]   fed_cand;
  logic [3:0]       fed_pos;
  logic [ID_W-1:0]  fed_acc;
  logic [3:0]       fed_dcnt;
  logic             fed_bad;
  logic             text_ok;
  logic             text_part;

  assign b             = s_axis_tdata;
  assign s_axis_tready = !q_full;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign is_sep        = (b == SEP);
  assign is_digit      = (b >= 8'h30) && (b <= 8'h39);
  assign dval          = 4'(b - 8'h30);
  assign prod          = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + (ID_W+4)'(dval);

  // Feeding one byte into the current field: keyword match and number build.
  always_comb begin
    for (int k = 0; k < NKW; k++) begin
      fed_cand[k] = cand[k] && (pos < kw_len(k)) && (kw_char(k, pos[2:0]) == b);
    end
    fed_pos  = (pos < 4'd15) ? pos + 4'd1 : pos;
    fed_acc  = acc;
    fed_dcnt = dcnt;
    fed_bad  = nbad;
    if (!is_digit || (dcnt >= MAX_DIGITS)) begin
      fed_bad = 1'b1;
    end else begin
      fed_dcnt = dcnt + 4'd1;
      if (prod > (ID_W+4)'(ID_MAX)) begin
        fed_bad = 1'b1;
      end else begin
        fed_acc = prod[ID_W-1:0];
      end
    end
  end

  always_comb begin
    phase_next  = phase;
    cand_next   = cand;
    pos_next    = pos;
    acc_next    = acc;
    dcnt_next   = dcnt;
    nbad_next   = nbad;
    hident_next = hident;
    hlevel_next = hlevel;
    hkind_next  = hkind;
    hrun_next   = hrun;
    tcnt_next   = tcnt;
    ferr_next   = ferr || (b == 8'h00);
    text_ok     = 1'b0;
    text_part   = 1'b0;
    q_entry     = '0;

    unique case (phase)
      PH_HEAD, PH_FID, PH_FSTATE, PH_GMV, PH_WVAL, PH_WTYPE: begin
        if (is_sep) begin
          if (phase == PH_HEAD) begin
            if (kw_hit(cand, pos, KW_FUNC)) begin
              phase_next = PH_FID;
            end else if (kw_hit(cand, pos, KW_GM)) begin
              phase_next = PH_GMV;
            end else if (kw_hit(cand, pos, KW_API)) begin
              phase_next = PH_QUERY;
              tcnt_next  = '0;
            end else if (num_ok(nbad, dcnt, acc, ID_MAX)) begin
              hident_next = acc;
              phase_next  = PH_WTYPE;
            end else begin
              ferr_next  = 1'b1;
              phase_next = PH_DONE;
            end
          end else if (phase == PH_FID) begin
            if (num_ok(nbad, dcnt, acc, ID_MAX)) begin
              hident_next = acc;
              phase_next  = PH_FSTATE;
            end else begin
              ferr_next  = 1'b1;
              phase_next = PH_DONE;
            end
          end else if (phase == PH_WTYPE) begin
            if (kw_hit(cand, pos, KW_BUTTON)) begin
              hkind_next = KIND_BUTTON;
              phase_next = PH_WVAL;
            end else if (kw_hit(cand, pos, KW_SLIDER)) begin
              hkind_next = KIND_SLIDER;
              phase_next = PH_WVAL;
            end else begin
              hkind_next = KIND_UNKNOWN;
              phase_next = PH_DONE;
            end
          end else if (phase == PH_FSTATE) begin
            phase_next = PH_DONE;
            if (kw_hit(cand, pos, KW_RUN)) begin
              hrun_next  = 1'b1;
              hkind_next = KIND_FUNCTION;
            end else if (kw_hit(cand, pos, KW_STOP)) begin
              hrun_next  = 1'b0;
              hkind_next = KIND_FUNCTION;
            end else begin
              ferr_next = 1'b1;
            end
          end else begin
            // Grand-master level or widget level closes here.
            phase_next = PH_DONE;
            if (num_ok(nbad, dcnt, acc, LEVEL_MAX)) begin
              hlevel_next = acc[LVL_W-1:0];
              if (phase == PH_GMV) begin
                hkind_next = KIND_GM;
              end
            end else begin
              ferr_next = 1'b1;
            end
          end
          cand_next = KW_ALL;
          pos_next  = '0;
          acc_next  = '0;
          dcnt_next = '0;
          nbad_next = 1'b0;
        end else begin
          cand_next = fed_cand;
          pos_next  = fed_pos;
          acc_next  = fed_acc;
          dcnt_next = fed_dcnt;
          nbad_next = fed_bad;
        end
      end
      PH_QUERY: begin
        if (is_sep) begin
          phase_next = PH_PAYLOAD;
          tcnt_next  = '0;
        end else if ({1'b0, tcnt} < (CNT_W+1)'(QUERY_CAP - 1)) begin
          tcnt_next = tcnt + 1'b1;
          text_ok   = 1'b1;
        end
      end
      PH_PAYLOAD: begin
        if ({1'b0, tcnt} < (CNT_W+1)'(PAYLOAD_CAP - 1)) begin
          tcnt_next = tcnt + 1'b1;
          text_ok   = 1'b1;
          text_part = 1'b1;
        end
      end
      default: begin
      end
    endcase

    q_entry.has_text  = text_ok;
    q_entry.text_byte = b;
    q_entry.text_part = text_part;

    if (s_axis_tlast) begin
      unique case (phase_next)
        PH_FSTATE: begin
          if (kw_hit(cand_next, pos_next, KW_RUN)) begin
            hrun_next  = 1'b1;
            hkind_next = KIND_FUNCTION;
          end else if (kw_hit(cand_next, pos_next, KW_STOP)) begin
            hrun_next  = 1'b0;
            hkind_next = KIND_FUNCTION;
          end else begin
            ferr_next = 1'b1;
          end
        end
        PH_GMV, PH_WVAL: begin
          if (num_ok(nbad_next, dcnt_next, acc_next, LEVEL_MAX)) begin
            hlevel_next = acc_next[LVL_W-1:0];
            if (phase_next == PH_GMV) begin
              hkind_next = KIND_GM;
            end
          end else begin
            ferr_next = 1'b1;
          end
        end
        PH_QUERY, PH_PAYLOAD: begin
          hkind_next = KIND_API;
        end
        PH_WTYPE: begin
          if (kw_hit(cand_next, pos_next, KW_BUTTON) ||
              kw_hit(cand_next, pos_next, KW_SLIDER)) begin
            ferr_next = 1'b1;
          end else begin
            hkind_next = KIND_UNKNOWN;
          end
        end
        PH_DONE: begin
        end
        default: begin
          // Head or function id still open: a needed field is missing.
          ferr_next = 1'b1;
        end
      endcase

      q_entry.has_verdict = 1'b1;
      q_entry.malformed   = ferr_next;
      if (!ferr_next) begin
        q_entry.kind    = hkind_next;
        q_entry.ident   = hident_next;
        q_entry.level   = hlevel_next;
        q_entry.running = hrun_next;
      end

      // Every frame starts from the reset state.
      phase_next  = PH_HEAD;
      cand_next   = KW_ALL;
      pos_next    = '0;
      acc_next    = '0;
      dcnt_next   = '0;
      nbad_next   = 1'b0;
      hident_next = '0;
      hlevel_next = '0;
      hkind_next  = KIND_UNKNOWN;
      hrun_next   = 1'b0;
      tcnt_next   = '0;
      ferr_next   = 1'b0;
    end

    q_push = accept && (text_ok || s_axis_tlast);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= PH_HEAD;
      cand   <= KW_ALL;
      pos    <= '0;
      acc    <= '0;
      dcnt   <= '0;
      nbad   <= 1'b0;
      hident <= '0;
      hlevel <= '0;
      hkind  <= KIND_UNKNOWN;
      hrun   <= 1'b0;
      tcnt   <= '0;
      ferr   <= 1'b0;
    end else if (accept) begin
      phase  <= phase_next;
      cand   <= cand_next;
      pos    <= pos_next;
      acc    <= acc_next;
      dcnt   <= dcnt_next;
      nbad   <= nbad_next;
      hident <= hident_next;
      hlevel <= hlevel_next;
      hkind  <= hkind_next;
      hrun   <= hrun_next;
      tcnt   <= tcnt_next;
      ferr   <= ferr_next;
    end
  end

endmodule

FILE: rtl/pfcp_back.sv
// ----------------------------------------------------------------------------
// pfcp_back: result emitter
// Turns queued entries into result beats held in an output register.
// ----------------------------------------------------------------------------
module pfcp_back (
  input  logic                  clk,
  input  logic                  rst,
  input  pfcp_pkg::pfcp_entry_t head,
  input  logic                  empty,
  output logic                  pop,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [47:0]           m_axis_tdata,
  output logic [2:0]            m_axis_tuser,
  output logic                  m_axis_tlast
);
  import pfcp_pkg::*;

  logic text_sent;
  logic load;
  logic emit_text;

  assign load      = (!m_axis_tvalid || m_axis_tready) && !empty;
  assign emit_text = head.has_text && !text_sent;
  // An entry with both a text byte and a verdict leaves after its second beat.
  assign pop       = load && !(emit_text && head.has_verdict);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      text_sent     <= 1'b0;
    end else begin
      if (load) begin
        m_axis_tvalid <= 1'b1;
        text_sent     <= emit_text && head.has_verdict;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (emit_text) begin
        m_axis_tdata <= {40'd0, head.text_byte};
        m_axis_tuser <= {1'b0, head.text_part, 1'b1};
        m_axis_tlast <= !head.has_verdict;
      end else begin
        m_axis_tdata <= {head.running, head.level, head.ident, head.kind,
                         head.malformed, 8'd0};
        m_axis_tuser <= 3'b100;
        m_axis_tlast <= 1'b1;
      end
    end
  end

endmodule

FILE: rtl/pipe_field_command_parser.sv
// ----------------------------------------------------------------------------
// pipe_field_command_parser: pipe-separated text frame classifier
// Accepts one frame byte per cycle; the front parser never waits on a result
// except when the four-entry queue is full. A result beat passes through the
// queue into the output register. A byte that ends an api frame inside its
// text gives two beats, and the back end pops its entry with the second.
// A synchronous reset returns the parser to the head field of a new frame
// and empties the queue and the output register.
// ----------------------------------------------------------------------------
module pipe_field_command_parser #(
  parameter int QUERY_CAP   = pfcp_pkg::QUERY_CAP_DEF,
  parameter int PAYLOAD_CAP = pfcp_pkg::PAYLOAD_CAP_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // Frame bytes in.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] frame_byte
  input  logic        s_axis_tlast,   // frame_end
  // Result beats out.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] text_byte, [8] malformed, [11:9] frame_kind, [38:12] ident,
  // [46:39] level, [47] running
  output logic [47:0] m_axis_tdata,
  // [0] text_valid, [1] text_part, [2] frame_done
  output logic [2:0]  m_axis_tuser,
  output logic        m_axis_tlast    // run_last
);
  import pfcp_pkg::*;

  // The front parses and classifies each byte into one queue entry that can
  // carry a streamed text byte, an end-of-frame verdict, or both.
  pfcp_entry_t push_entry;
  pfcp_entry_t head_entry;
  logic        push;
  logic        full;
  logic        pop;
  logic        empty;

  pfcp_front #(
    .QUERY_CAP   (QUERY_CAP),
    .PAYLOAD_CAP (PAYLOAD_CAP)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .q_push        (push),
    .q_entry       (push_entry),
    .q_full        (full)
  );

  // The queue lets the parser keep taking bytes while the consumer stalls.
  pfcp_queue #(
    .WIDTH ($bits(pfcp_entry_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_entry),
    .full      (full),
    .pop       (pop),
    .pop_data  (head_entry),
    .empty     (empty)
  );

  // The back end expands entries into beats; a verdict beat always closes
  // its byte's run, and a text beat does so when no verdict follows it.
  pfcp_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head_entry),
    .empty         (empty),
    .pop           (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

FILE: tb/pipe_field_command_parser_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pipe_field_command_parser_tb: self-checking bench for the frame parser
// Streams pipe-separated text frames into the parser one byte per beat and
// checks every result beat against a cycle-free model of the parser that
// runs alongside. Both stream sides idle at random, and the result side
// holds off once for a long stretch so that the parser queue fills up.
// ----------------------------------------------------------------------------
module pipe_field_command_parser_tb;
  import pfcp_pkg::*;

  // One result beat, split into the fields that the parser reports.
  typedef struct packed {
    logic              text_valid;
    logic [7:0]        text_byte;
    logic              text_part;
    logic              frame_done;
    logic              malformed;
    logic [KND_W-1:0]  kind;
    logic [ID_W-1:0]   ident;
    logic [LVL_W-1:0]  level;
    logic              running;
    logic              run_last;
  } result_beat_t;

  // Frame tracker: follows the parse of each accepted byte and keeps the
  // result beats that the parser owes, oldest first.
  class parse_scoreboard;
    typedef enum logic [3:0] {
      PH_HEAD, PH_FUNC_ID, PH_FUNC_STATE, PH_GM_LEVEL, PH_QUERY, PH_PAYLOAD,
      PH_WIDGET_TYPE, PH_WIDGET_LEVEL, PH_CLOSED
    } phase_e;

    string            kw_word [NKW];
    phase_e           phase;
    logic [NKW-1:0]   cand;
    logic [3:0]       pos;
    logic [ID_W-1:0]  acc;
    logic [3:0]       ndig;
    bit               num_bad;
    logic [ID_W-1:0]  id_held;
    logic [LVL_W-1:0] level_held;
    logic [KND_W-1:0] kind_held;
    bit               run_held;
    int unsigned      text_n;
    bit               frame_bad;
    result_beat_t     owed_beats [$];
    int               failures;

    function new();
      kw_word[KW_FUNC]   = "FUNCTION";
      kw_word[KW_GM]     = "GM_";
      kw_word[KW_GM]     = {kw_word[KW_GM], "VALUE"};
      kw_word[KW_API]    = "QLC";
      kw_word[KW_API]    = {kw_word[KW_API], "+API"};
      kw_word[KW_BUTTON] = "BUTTON";
      kw_word[KW_SLIDER] = "SLIDER";
      kw_word[KW_RUN]    = "Running";
      kw_word[KW_STOP]   = "Stopped";
      failures = 0;
      restart();
    endfunction

    function void clear_field();
      cand    = KW_ALL;
      pos     = '0;
      acc     = '0;
      ndig    = '0;
      num_bad = 1'b0;
    endfunction

    function void restart();
      phase      = PH_HEAD;
      clear_field();
      id_held    = '0;
      level_held = '0;
      kind_held  = KIND_UNKNOWN;
      run_held   = 1'b0;
      text_n     = 0;
      frame_bad  = 1'b0;
    endfunction

    function void take_char(logic [7:0] b);
      logic [63:0] v;
      for (int k = 0; k < NKW; k++) begin
        if (pos >= kw_word[k].len() || 8'(kw_word[k][pos]) != b) cand[k] = 1'b0;
      end
      if (pos < 4'd15) pos++;
      if (b < "0" || b > "9" || ndig >= MAX_DIGITS) begin
        num_bad = 1'b1;
      end else begin
        v = 64'(acc) * 10 + 64'(b - 8'h30);
        ndig++;
        if (v > 64'(ID_MAX)) num_bad = 1'b1;
        else acc = v[ID_W-1:0];
      end
    endfunction

    function bit keyword_matched(int k);
      return cand[k] && (int'(pos) == kw_word[k].len());
    endfunction

    function bit number_fits(logic [ID_W-1:0] max);
      return !num_bad && ndig != 0 && acc <= max;
    endfunction

    function void reject();
      frame_bad = 1'b1;
      phase     = PH_CLOSED;
    endfunction

    // Closes the last field of a function, grand master or widget frame.
    function void close_value();
      if (phase == PH_FUNC_STATE) begin
        if (keyword_matched(KW_RUN)) begin
          run_held  = 1'b1;
          kind_held = KIND_FUNCTION;
        end else if (keyword_matched(KW_STOP)) begin
          run_held  = 1'b0;
          kind_held = KIND_FUNCTION;
        end else begin
          reject();
          return;
        end
      end else begin
        if (!number_fits(LEVEL_MAX)) begin
          reject();
          return;
        end
        level_held = acc[LVL_W-1:0];
        if (phase == PH_GM_LEVEL) kind_held = KIND_GM;
      end
      phase = PH_CLOSED;
    endfunction

    function void note_byte(logic [7:0] b, logic last);
      result_beat_t run [$];
      result_beat_t r;
      if (b == 8'h00) frame_bad = 1'b1;
      case (phase)
        PH_HEAD: begin
          if (b == SEP) begin
            if (keyword_matched(KW_FUNC)) phase = PH_FUNC_ID;
            else if (keyword_matched(KW_GM)) phase = PH_GM_LEVEL;
            else if (keyword_matched(KW_API)) begin
              phase  = PH_QUERY;
              text_n = 0;
            end else if (number_fits(ID_MAX)) begin
              id_held = acc;
              phase   = PH_WIDGET_TYPE;
            end else reject();
            clear_field();
          end else take_char(b);
        end
        PH_FUNC_ID: begin
          if (b == SEP) begin
            if (number_fits(ID_MAX)) begin
              id_held = acc;
              phase   = PH_FUNC_STATE;
            end else reject();
            clear_field();
          end else take_char(b);
        end
        PH_FUNC_STATE, PH_GM_LEVEL, PH_WIDGET_LEVEL: begin
          if (b == SEP) begin
            close_value();
            clear_field();
          end else take_char(b);
        end
        PH_QUERY: begin
          if (b == SEP) begin
            phase  = PH_PAYLOAD;
            text_n = 0;
          end else if (text_n < QUERY_CAP_DEF - 1) begin
            text_n++;
            r = '0;
            r.text_valid = 1'b1;
            r.text_byte  = b;
            run.push_back(r);
          end
        end
        PH_PAYLOAD: begin
          // Separators inside the payload are plain text.
          if (text_n < PAYLOAD_CAP_DEF - 1) begin
            text_n++;
            r = '0;
            r.text_valid = 1'b1;
            r.text_byte  = b;
            r.text_part  = 1'b1;
            run.push_back(r);
          end
        end
        PH_WIDGET_TYPE: begin
          if (b == SEP) begin
            if (keyword_matched(KW_BUTTON)) begin
              kind_held = KIND_BUTTON;
              phase     = PH_WIDGET_LEVEL;
            end else if (keyword_matched(KW_SLIDER)) begin
              kind_held = KIND_SLIDER;
              phase     = PH_WIDGET_LEVEL;
            end else begin
              kind_held = KIND_UNKNOWN;
              phase     = PH_CLOSED;
            end
            clear_field();
          end else take_char(b);
        end
        default: ;
      endcase

      if (last) begin
        case (phase)
          PH_FUNC_STATE, PH_GM_LEVEL, PH_WIDGET_LEVEL: close_value();
          PH_QUERY, PH_PAYLOAD: begin
            kind_held = KIND_API;
            phase     = PH_CLOSED;
          end
          PH_WIDGET_TYPE: begin
            // A known widget type with no level after it is incomplete.
            if (keyword_matched(KW_BUTTON) || keyword_matched(KW_SLIDER)) reject();
            else begin
              kind_held = KIND_UNKNOWN;
              phase     = PH_CLOSED;
            end
          end
          PH_CLOSED: ;
          default: reject();
        endcase
        r = '0;
        r.frame_done = 1'b1;
        if (frame_bad) r.malformed = 1'b1;
        else begin
          r.kind    = kind_held;
          r.ident   = id_held;
          r.level   = level_held;
          r.running = run_held;
        end
        run.push_back(r);
        restart();
      end

      if (run.size() > 0) run[run.size()-1].run_last = 1'b1;
      foreach (run[i]) owed_beats.push_back(run[i]);
    endfunction

    function string show(result_beat_t r);
      return $sformatf({"tv=%0b byte=%02h part=%0b done=%0b bad=%0b kind=%0d",
                        " id=%0d lvl=%0d run=%0b last=%0b"},
                       r.text_valid, r.text_byte, r.text_part, r.frame_done, r.malformed,
                       r.kind, r.ident, r.level, r.running, r.run_last);
    endfunction

    function void check_beat(logic [47:0] d, logic [2:0] u, logic l);
      result_beat_t got;
      result_beat_t want;
      got.text_byte  = d[7:0];
      got.malformed  = d[8];
      got.kind       = d[11:9];
      got.ident      = d[38:12];
      got.level      = d[46:39];
      got.running    = d[47];
      got.text_valid = u[0];
      got.text_part  = u[1];
      got.frame_done = u[2];
      got.run_last   = l;
      if (owed_beats.size() == 0) begin
        failures++;
        if (failures <= 10) begin
          $display("%0t: result beat with nothing owed: %s", $time, show(got));
        end
        return;
      end
      want = owed_beats.pop_front();
      if (got !== want) begin
        failures++;
        if (failures <= 10) begin
          $display("%0t: result beat mismatch", $time);
          $display("  expected %s", show(want));
          $display("  actual   %s", show(got));
        end
      end
    endfunction

    function int pending();
      return owed_beats.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and the parser itself.
  // --------------------------------------------------------------------------
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_valid = 1'b0;
  logic        s_ready;
  logic [7:0]  s_data = '0;
  logic        s_last = 1'b0;
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [47:0] m_data;
  logic [2:0]  m_user;
  logic        m_last;

  parse_scoreboard sb = new();

  bit [7:0] frame_buf [$];  // bytes of the frame being built
  int       bytes_sent = 0;
  int       send_calm  = 0;  // bytes left in a stretch without sender gaps
  int       recv_calm  = 0;  // beats left in a stretch without receiver stalls

  initial begin
    forever #10 clk = ~clk;
  end

  pipe_field_command_parser #(
    .QUERY_CAP   (QUERY_CAP_DEF),
    .PAYLOAD_CAP (PAYLOAD_CAP_DEF)
  ) u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .s_axis_tlast  (s_last),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data),
    .m_axis_tuser  (m_user),
    .m_axis_tlast  (m_last)
  );

  // --------------------------------------------------------------------------
  // Frame building. Most helpers append to frame_buf; mutate_frame alters it.
  // --------------------------------------------------------------------------
  function automatic void put_str(string s);
    for (int i = 0; i < s.len(); i++) frame_buf.push_back(s[i]);
  endfunction

  // A number field: mostly legal values, with the odd empty, overlong,
  // out-of-range or signed field mixed in.
  function automatic void put_num(logic [ID_W-1:0] max);
    logic [ID_W:0] v;
    string         s;
    s = "";
    case ($urandom_range(0, 19))
      0: s = "";
      1: s = $sformatf("%0d", max);
      2: s = $sformatf("%0d", {1'b0, max} + 1);
      3: s = "0000000001";
      4: begin
        v = $urandom_range(0, max);
        s = $sformatf("%09d", v);
      end
      5: s = $urandom_range(0, 1) ? "-1" : " 7";
      6: s = "0";
      default: begin
        v = $urandom_range(0, max);
        if (max == ID_MAX) v = v >> $urandom_range(0, 26);
        s = $sformatf("%0d", v);
      end
    endcase
    put_str(s);
  endfunction

  function automatic void put_state();
    case ($urandom_range(0, 11))
      0: put_str("Runnin");
      1: put_str("Stoppedd");
      2: put_str("running");
      3: ;
      default: put_str($urandom_range(0, 1) ? "Running" : "Stopped");
    endcase
  endfunction

  // Query text may not hold a separator, since that would end the query.
  function automatic logic [7:0] text_char(bit in_query);
    logic [7:0] c;
    c = ($urandom_range(0, 15) == 0) ? 8'($urandom_range(1, 255))
                                     : 8'($urandom_range(32, 126));
    if (in_query && c == SEP) c = "_";
    return c;
  endfunction

  function automatic void put_text(bit in_query, int n);
    for (int i = 0; i < n; i++) frame_buf.push_back(text_char(in_query));
  endfunction

  // Builds one random frame of the given form; forms 0 to 4 are the
  // well-formed shapes, anything else is raw noise.
  function automatic void build_frame(int form);
    int n;
    case (form)
      0: begin
        put_str("FUNCTION|");
        put_num(ID_MAX);
        put_str("|");
        put_state();
      end
      1: begin
        put_str({sb.kw_word[KW_GM], "|"});
        put_num(LEVEL_MAX);
      end
      2: begin
        put_str({sb.kw_word[KW_API], "|"});
        put_text(1'b1, ($urandom_range(0, 5) == 0) ? $urandom_range(25, 40)
                                                   : $urandom_range(0, 8));
        if ($urandom_range(0, 9) != 0) begin
          put_str("|");
          put_text(1'b0, ($urandom_range(0, 30) == 0) ? $urandom_range(250, 270)
                                                      : $urandom_range(0, 12));
        end
      end
      3: begin
        put_num(ID_MAX);
        put_str($urandom_range(0, 1) ? "|BUTTON|" : "|SLIDER|");
        put_num(LEVEL_MAX);
      end
      4: begin
        put_num(ID_MAX);
        put_str("|");
        case ($urandom_range(0, 5))
          0: put_str("BUTTO");
          1: put_str("SLIDERS");
          default: begin
            n = $urandom_range(0, 8);
            for (int i = 0; i < n; i++) frame_buf.push_back(8'($urandom_range(65, 90)));
          end
        endcase
      end
      default: begin
        n = $urandom_range(1, 12);
        for (int i = 0; i < n; i++) frame_buf.push_back(8'($urandom_range(0, 255)));
      end
    endcase
    // Extra fields: ignored by the parser, but payload text in an api frame.
    if (form <= 4 && $urandom_range(0, 5) == 0) begin
      put_str("|x");
      put_text(1'b0, $urandom_range(0, 3));
    end
  endfunction

  // Breaks a finished frame: one byte overwritten, the tail cut off, or a
  // NUL slipped in.
  function automatic void mutate_frame();
    int keep;
    case ($urandom_range(0, 2))
      0: frame_buf[$urandom_range(0, frame_buf.size() - 1)] = 8'($urandom_range(0, 255));
      1: begin
        keep = $urandom_range(1, frame_buf.size());
        while (frame_buf.size() > keep) void'(frame_buf.pop_back());
      end
      default: frame_buf.insert($urandom_range(0, frame_buf.size()), 8'h00);
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Sender. Each byte waits a random idle gap before it is offered, apart
  // from occasional stretches where bytes go back to back. The byte is
  // handed to the scoreboard at the edge where its beat is taken.
  // --------------------------------------------------------------------------
  task automatic push_byte(input logic [7:0] b, input logic last);
    int gap;
    if (send_calm > 0) begin
      gap = 0;
      send_calm--;
    end else begin
      gap = $urandom_range(0, 6);
      if ($urandom_range(0, 24) == 0) send_calm = 40;
    end
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_valid <= 1'b1;
    s_data  <= b;
    s_last  <= last;
    do @(posedge clk); while (!s_ready);
    sb.note_byte(b, last);
    bytes_sent++;
  endtask

  task automatic send_frame();
    foreach (frame_buf[i]) push_byte(frame_buf[i], i == frame_buf.size() - 1);
    frame_buf.delete();
  endtask

  // --------------------------------------------------------------------------
  // Receiver. It stalls for a random gap before each beat, and once, early
  // in the run, it holds off while the sender keeps going, so the parser
  // queue fills and the input side has to wait.
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int gap;
    int beats;
    bit held_off;
    beats    = 0;
    held_off = 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (beats == 60 && !held_off) begin
        held_off = 1'b1;
        m_ready <= 1'b0;
        repeat (300) @(posedge clk);
      end
      if (recv_calm > 0) begin
        gap = 0;
        recv_calm--;
      end else begin
        gap = $urandom_range(0, 6);
        if ($urandom_range(0, 24) == 0) recv_calm = 40;
      end
      if (gap > 0) begin
        m_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_ready <= 1'b1;
      do @(posedge clk); while (!m_valid);
      sb.check_beat(m_data, m_user, m_last);
      beats++;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus: a directed set of frames, then random frames until about 1100
  // bytes have gone in altogether. Then drain and report.
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int stop_at;
    int r;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Function frames: smallest and largest id, id overflow, wrong case,
    // missing id and state fields, and a trailing separator.
    put_str("FUNCTION|0|Running");          send_frame();
    put_str("FUNCTION|134217727|Stopped");  send_frame();
    put_str("FUNCTION|134217728|Running");  send_frame();
    put_str("FUNCTION|3|running");          send_frame();
    put_str("FUNCTION|");                   send_frame();
    put_str("FUNCTION|1|Running|");         send_frame();
    // Grand master: top level, level overflow, extra fields.
    put_str({sb.kw_word[KW_GM], "|255"});      send_frame();
    put_str({sb.kw_word[KW_GM], "|256"});      send_frame();
    put_str({sb.kw_word[KW_GM], "|0|extra"});  send_frame();
    // Api frames: empty payload, separators inside the payload, no separator
    // after the head, a NUL inside the query.
    put_str({sb.kw_word[KW_API], "|getWidgetsList|"});  send_frame();
    put_str({sb.kw_word[KW_API], "|q|p|ay|load"});      send_frame();
    put_str(sb.kw_word[KW_API]);                        send_frame();
    put_str({sb.kw_word[KW_API], "|a"});
    frame_buf.push_back(8'h00);
    put_str("b|c");
    send_frame();
    // Query and payload both past their capacity.
    put_str({sb.kw_word[KW_API], "|"});
    put_text(1'b1, 40);
    put_str("|");
    put_text(1'b0, 300);
    send_frame();
    // Widgets: both known types at the level extremes, unknown and empty
    // types, a known type with no level, a ten-digit id, an empty level.
    put_str("42|BUTTON|0");                 send_frame();
    put_str("134217727|SLIDER|255");        send_frame();
    put_str("5|KNOB");                      send_frame();
    put_str("5|");                          send_frame();
    put_str("5|BUTTON");                    send_frame();
    put_str("5|BUTTONS|1");                 send_frame();
    put_str("1234567890|BUTTON|1");         send_frame();
    put_str("5|SLIDER|");                   send_frame();
    // Single-byte frames: a bare separator, a letter, an all-ones byte.
    put_str("|");                           send_frame();
    put_str("X");                           send_frame();
    frame_buf.push_back(8'hFF);             send_frame();

    // Random part: mostly well-formed frames with random content, the rest
    // broken frames and noise.
    stop_at = 1100;
    while (bytes_sent < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 15) build_frame(0);
      else if (r < 25) build_frame(1);
      else if (r < 45) build_frame(2);
      else if (r < 62) build_frame(3);
      else if (r < 72) build_frame(4);
      else if (r < 80) build_frame(5);
      else begin
        build_frame($urandom_range(0, 4));
        mutate_frame();
      end
      send_frame();
    end
    s_valid <= 1'b0;

    // Wait for every owed beat, then a few more cycles to catch strays.
    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.failures == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run of this stimulus.
  initial begin : watchdog
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
